// ===== src/assert_macros.svh =====
// Assertion macros shared by the velocity block modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define APV_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen at a rising edge outside reset.
`define APV_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/apv_pkg.sv =====
// Package for the attractive potential velocity block: register widths,
// register indexes, fixed-point constants and the flag struct. No dependencies.
package apv_pkg;

  // Default coordinate width (signed, Q7.8 by default).
  localparam int unsigned COORD_BITS_DEF = 16;

  // Configuration register widths and reset values.
  localparam int unsigned SD_W     = 15;
  localparam int unsigned GAIN_W   = 12;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [SD_W-1:0]   SD_RESET   = 15'd512;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_DIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTRACT_GAIN = 2'd1;

  // Gain fraction bits; the radicand carries twice as many extra fraction bits, the root as many.
  localparam int unsigned GAIN_FRAC   = 8;
  localparam int unsigned SQRT_EXTRA  = 2 * GAIN_FRAC;
  localparam int unsigned K_W         = SD_W + GAIN_W;
  // Conical magnitude is at most k / 2^GAIN_FRAC + 1.
  localparam int unsigned QUOT_W      = K_W + 1 - GAIN_FRAC;

  // Per-item flags carried down the pipeline.
  typedef struct packed {
    logic conical;
    logic neg_x;
    logic neg_y;
  } apv_flags_t;

  localparam int unsigned FLAGS_W = $bits(apv_flags_t);

endpackage

// ===== src/apv_if.sv =====
// Valid/ready channel interfaces for position requests and velocity results.
// Depends on nothing.
interface apv_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] goal_x;
  logic signed [COORD_BITS-1:0] goal_y;

  modport source (output valid, start_x, start_y, goal_x, goal_y, input ready);
  modport sink   (input valid, start_x, start_y, goal_x, goal_y, output ready);
endinterface

interface apv_out_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vel_x;
  logic signed [COORD_BITS-1:0] vel_y;
  logic                         conical_case;
  logic                         saturated;

  modport source (output valid, vel_x, vel_y, conical_case, saturated, input ready);
  modport sink   (input valid, vel_x, vel_y, conical_case, saturated, output ready);
endinterface

// ===== src/attractive_potential_velocity.sv =====
// Attractive potential velocity block: takes one start/goal position request
// per cycle while in_if.ready is high and returns one velocity result per
// request, in order. The pipeline is three front stages, a square root that
// settles one root bit per stage, a rounding stage plus one stage per quotient
// bit of the two-lane divider, and the output register. The output register
// has a one-entry skid behind it, so a request is still accepted in the cycle
// a result waits; ready drops only while the skid holds a result. Registers
// are written through cfg_we_i/cfg_idx_i and must only be changed while the
// pipeline is empty.
`include "assert_macros.svh"

module attractive_potential_velocity #(
  parameter int unsigned COORD_BITS = apv_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [apv_pkg::CFG_W-1:0]     cfg_wdata_i,
  apv_in_if.sink                        in_if,
  apv_out_if.source                     out_if
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned D2_W   = 2 * C + 1;
  localparam int unsigned ROOT_W = (D2_W + apv_pkg::SQRT_EXTRA + 1) / 2;
  localparam int unsigned KA_W   = apv_pkg::K_W + C;
  localparam int unsigned MQ_W   = C + apv_pkg::GAIN_W + 1 - apv_pkg::GAIN_FRAC;
  localparam int unsigned QW     = apv_pkg::QUOT_W;
  localparam int unsigned FW     = apv_pkg::FLAGS_W;
  localparam int unsigned SIDE1_W = FW + 2 * KA_W + 2 * MQ_W;
  localparam int unsigned SIDE2_W = FW + 2 * MQ_W;
  localparam int unsigned MW     = (MQ_W > QW) ? MQ_W : QW;
  localparam int unsigned CW     = ((MW > C) ? MW : C) + 1;
  localparam int unsigned RES_W  = 2 * C + 2;
  localparam logic [CW-1:0] LIM_POS = {{(CW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic [CW-1:0] LIM_NEG = LIM_POS + CW'(1);

  // Configuration registers.
  logic [apv_pkg::SD_W-1:0]   sd_q;
  logic [apv_pkg::GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_q   <= apv_pkg::SD_RESET;
      gain_q <= apv_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apv_pkg::REG_SWITCH_DIST:  sd_q   <= cfg_wdata_i[apv_pkg::SD_W-1:0];
        apv_pkg::REG_ATTRACT_GAIN: gain_q <= cfg_wdata_i[apv_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances while the skid entry is free.
  logic skid_valid_q;
  logic en;
  assign en          = !skid_valid_q;
  assign in_if.ready = en;

  // Front stages.
  logic                f_valid;
  apv_pkg::apv_flags_t f_flags;
  logic [D2_W-1:0]     f_dist2;
  logic [KA_W-1:0]     f_ka_x, f_ka_y;
  logic [MQ_W-1:0]     f_mq_x, f_mq_y;

  apv_front #(
    .COORD_BITS (C)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_if.valid),
    .start_x_i (in_if.start_x),
    .start_y_i (in_if.start_y),
    .goal_x_i  (in_if.goal_x),
    .goal_y_i  (in_if.goal_y),
    .sd_i      (sd_q),
    .gain_i    (gain_q),
    .valid_o   (f_valid),
    .flags_o   (f_flags),
    .dist2_o   (f_dist2),
    .ka_x_o    (f_ka_x),
    .ka_y_o    (f_ka_y),
    .mq_x_o    (f_mq_x),
    .mq_y_o    (f_mq_y)
  );

  // Root of the squared distance with extra fraction bits.
  logic [2*ROOT_W-1:0] sq_value;
  logic                s_valid;
  logic [ROOT_W-1:0]   s_root;
  logic [SIDE1_W-1:0]  s_side;
  assign sq_value = (2*ROOT_W)'(f_dist2) << apv_pkg::SQRT_EXTRA;

  apv_sqrt #(
    .ROOT_W (ROOT_W),
    .SIDE_W (SIDE1_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .value_i (sq_value),
    .side_i  ({f_flags, f_ka_x, f_ka_y, f_mq_x, f_mq_y}),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // Conical magnitudes.
  apv_pkg::apv_flags_t s_flags;
  logic [KA_W-1:0]     s_ka_x, s_ka_y;
  logic [MQ_W-1:0]     s_mq_x, s_mq_y;
  assign {s_flags, s_ka_x, s_ka_y, s_mq_x, s_mq_y} = s_side;

  logic                d_valid;
  logic [QW-1:0]       d_q_x, d_q_y;
  logic [SIDE2_W-1:0]  d_side;

  apv_div #(
    .ROOT_W (ROOT_W),
    .KA_W   (KA_W),
    .QUOT_W (QW),
    .SIDE_W (SIDE2_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_valid),
    .root_i   (s_root),
    .ka_x_i   (s_ka_x),
    .ka_y_i   (s_ka_y),
    .side_i   ({s_flags, s_mq_x, s_mq_y}),
    .valid_o  (d_valid),
    .quot_x_o (d_q_x),
    .quot_y_o (d_q_y),
    .side_o   (d_side)
  );

  // Case select, sign and saturation.
  apv_pkg::apv_flags_t d_flags;
  logic [MQ_W-1:0]     d_mq_x, d_mq_y;
  logic [CW-1:0]       mag_x, mag_y, lim_x, lim_y, cl_x, cl_y, neg_x, neg_y;
  logic                clip_x, clip_y;
  logic [RES_W-1:0]    fin;
  logic                fin_valid;

  assign {d_flags, d_mq_x, d_mq_y} = d_side;
  assign mag_x  = d_flags.conical ? CW'(d_q_x) : CW'(d_mq_x);
  assign mag_y  = d_flags.conical ? CW'(d_q_y) : CW'(d_mq_y);
  assign lim_x  = d_flags.neg_x ? LIM_NEG : LIM_POS;
  assign lim_y  = d_flags.neg_y ? LIM_NEG : LIM_POS;
  assign clip_x = mag_x > lim_x;
  assign clip_y = mag_y > lim_y;
  assign cl_x   = clip_x ? lim_x : mag_x;
  assign cl_y   = clip_y ? lim_y : mag_y;
  assign neg_x  = ~cl_x + CW'(1);
  assign neg_y  = ~cl_y + CW'(1);
  assign fin    = {d_flags.neg_x ? neg_x[C-1:0] : cl_x[C-1:0],
                   d_flags.neg_y ? neg_y[C-1:0] : cl_y[C-1:0],
                   d_flags.conical, clip_x | clip_y};
  assign fin_valid = d_valid && en;

  // Output register with a one-entry skid behind it.
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_d;
  logic [RES_W-1:0] out_q, out_d, skid_q, skid_d;
  logic             out_take;
  assign out_take = out_valid_q && out_if.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid_q || out_take) begin
        out_d       = fin;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = fin;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.vel_x        = out_q[RES_W-1 -: C];
  assign out_if.vel_y        = out_q[C+1:2];
  assign out_if.conical_case = out_q[1];
  assign out_if.saturated    = out_q[0];

  // The skid holds a result only behind a waiting output.
  `APV_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid full with empty output")
  `APV_ASSERT(a_skid_fill_on_stall, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(out_valid_q && !out_if.ready), "skid filled without a stall")
  `APV_ASSERT_NEVER(a_no_accept_skid_full, clk_i, rst_ni, in_if.valid && in_if.ready && skid_valid_q, "request accepted while skid full")

endmodule

// ===== src/apv_front.sv =====
// Front end: offsets, magnitudes, squares, products, case choice and the
// quadratic result, in three register stages. Depends on apv_pkg.
module apv_front #(
  parameter int unsigned COORD_BITS = apv_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [COORD_BITS-1:0]                  start_x_i,
  input  logic [COORD_BITS-1:0]                  start_y_i,
  input  logic [COORD_BITS-1:0]                  goal_x_i,
  input  logic [COORD_BITS-1:0]                  goal_y_i,
  input  logic [apv_pkg::SD_W-1:0]               sd_i,
  input  logic [apv_pkg::GAIN_W-1:0]             gain_i,
  output logic                                   valid_o,
  output apv_pkg::apv_flags_t                    flags_o,
  output logic [2*COORD_BITS:0]                  dist2_o,
  output logic [apv_pkg::K_W+COORD_BITS-1:0]     ka_x_o,
  output logic [apv_pkg::K_W+COORD_BITS-1:0]     ka_y_o,
  output logic [COORD_BITS+apv_pkg::GAIN_W-apv_pkg::GAIN_FRAC:0] mq_x_o,
  output logic [COORD_BITS+apv_pkg::GAIN_W-apv_pkg::GAIN_FRAC:0] mq_y_o
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned KA_W   = apv_pkg::K_W + C;
  localparam int unsigned PG_W   = C + apv_pkg::GAIN_W;
  localparam int unsigned D2_W   = 2 * C + 1;
  localparam int unsigned SD2_W  = 2 * apv_pkg::SD_W;
  localparam int unsigned CMP_W  = (D2_W > SD2_W) ? D2_W : SD2_W;
  localparam logic [PG_W:0] HALF = (PG_W+1)'(1) << (apv_pkg::GAIN_FRAC - 1);

  // Stage 1: exact offsets, their magnitudes, the gain product k and the squared switching distance.
  logic [C:0] dx, dy, ndx, ndy;
  assign dx  = {goal_x_i[C-1], goal_x_i} - {start_x_i[C-1], start_x_i};
  assign dy  = {goal_y_i[C-1], goal_y_i} - {start_y_i[C-1], start_y_i};
  assign ndx = ~dx + (C+1)'(1);
  assign ndy = ~dy + (C+1)'(1);

  logic                   v1_q;
  logic                   nx1_q, ny1_q;
  logic [C-1:0]           ax1_q, ay1_q;
  logic [apv_pkg::K_W-1:0] k1_q;
  logic [SD2_W-1:0]       sd2_1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx1_q   <= dx[C];
      ny1_q   <= dy[C];
      ax1_q   <= dx[C] ? ndx[C-1:0] : dx[C-1:0];
      ay1_q   <= dy[C] ? ndy[C-1:0] : dy[C-1:0];
      k1_q    <= apv_pkg::K_W'(sd_i) * apv_pkg::K_W'(gain_i);
      sd2_1_q <= SD2_W'(sd_i) * SD2_W'(sd_i);
    end
  end

  // Stage 2: squares, gain products and the conical numerator products.
  logic             v2_q;
  logic             nx2_q, ny2_q;
  logic [2*C-1:0]   sqx2_q, sqy2_q;
  logic [PG_W-1:0]  pgx2_q, pgy2_q;
  logic [KA_W-1:0]  kax2_q, kay2_q;
  logic [SD2_W-1:0] sd2_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      sqx2_q  <= (2*C)'(ax1_q) * (2*C)'(ax1_q);
      sqy2_q  <= (2*C)'(ay1_q) * (2*C)'(ay1_q);
      pgx2_q  <= PG_W'(ax1_q) * PG_W'(gain_i);
      pgy2_q  <= PG_W'(ay1_q) * PG_W'(gain_i);
      kax2_q  <= KA_W'(k1_q) * KA_W'(ax1_q);
      kay2_q  <= KA_W'(k1_q) * KA_W'(ay1_q);
      sd2_2_q <= sd2_1_q;
    end
  end

  // Stage 3: squared distance, case choice and rounded quadratic magnitude.
  logic [D2_W-1:0] dist2;
  logic [PG_W:0]   rqx, rqy;
  assign dist2 = D2_W'(sqx2_q) + D2_W'(sqy2_q);
  assign rqx   = (PG_W+1)'(pgx2_q) + HALF;
  assign rqy   = (PG_W+1)'(pgy2_q) + HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_o.conical <= CMP_W'(dist2) > CMP_W'(sd2_2_q);
      flags_o.neg_x   <= nx2_q;
      flags_o.neg_y   <= ny2_q;
      dist2_o         <= dist2;
      ka_x_o          <= kax2_q;
      ka_y_o          <= kay2_q;
      mq_x_o          <= rqx[PG_W:apv_pkg::GAIN_FRAC];
      mq_y_o          <= rqy[PG_W:apv_pkg::GAIN_FRAC];
    end
  end

endmodule

// ===== src/apv_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage, with a
// side word carried along. Depends on nothing outside itself.
module apv_sqrt #(
  parameter int unsigned ROOT_W = 25,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   value_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned IN_W  = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;

  logic              valid_q [ROOT_W];
  logic [IN_W-1:0]   val_q   [ROOT_W];
  logic [REM_W-1:0]  rem_q   [ROOT_W];
  logic [ROOT_W-1:0] root_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q  [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic              vin;
    logic [IN_W-1:0]   val_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (g == 0) begin : g_first
      assign vin     = valid_i;
      assign val_in  = value_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[g-1];
      assign val_in  = val_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_in[REM_W-3:0], val_in[IN_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[g]  <= val_in << 2;
        side_q[g] <= side_in;
        if (rem_sh >= trial) begin
          rem_q[g]  <= rem_sh - trial;
          root_q[g] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[g]  <= rem_sh;
          root_q[g] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

// ===== src/apv_div.sv =====
// Pipelined two-lane restoring divider for the conical case: one rounding
// stage, then one quotient bit per stage. Depends on assert_macros.svh.
`include "assert_macros.svh"

module apv_div #(
  parameter int unsigned ROOT_W = 25,
  parameter int unsigned KA_W   = 43,
  parameter int unsigned QUOT_W = 20,
  parameter int unsigned SIDE_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [ROOT_W-1:0]  root_i,
  input  logic [KA_W-1:0]    ka_x_i,
  input  logic [KA_W-1:0]    ka_y_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               valid_o,
  output logic [QUOT_W-1:0]  quot_x_o,
  output logic [QUOT_W-1:0]  quot_y_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int unsigned NUM_W = KA_W + 1;
  localparam int unsigned REM_W = ROOT_W + 1;
  localparam int unsigned NS    = QUOT_W + 1;

  logic              valid_q [NS];
  logic [ROOT_W-1:0] div_q   [NS];
  logic [REM_W-1:0]  rem_q   [NS][2];
  logic [QUOT_W-1:0] low_q   [NS][2];
  logic [SIDE_W-1:0] side_q  [NS];

  // Rounding stage: divisor floor of one, numerator plus half the divisor.
  logic [ROOT_W-1:0] div0;
  logic [NUM_W-1:0]  num0 [2];
  assign div0    = (root_i == '0) ? ROOT_W'(1) : root_i;
  assign num0[0] = NUM_W'(ka_x_i) + NUM_W'(div0 >> 1);
  assign num0[1] = NUM_W'(ka_y_i) + NUM_W'(div0 >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q[0]  <= div0;
      side_q[0] <= side_i;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= REM_W'(num0[l] >> QUOT_W);
        low_q[0][l] <= num0[l][QUOT_W-1:0];
      end
    end
  end

  // Quotient stages: the low word shifts out numerator bits, in quotient bits.
  for (genvar g = 1; g < NS; g++) begin : g_stage
    logic [REM_W:0] rem_sh [2];
    logic [REM_W:0] div_ext;
    logic           take   [2];

    assign div_ext = (REM_W+1)'(div_q[g-1]);
    for (genvar l = 0; l < 2; l++) begin : g_lane
      assign rem_sh[l] = {rem_q[g-1][l], low_q[g-1][l][QUOT_W-1]};
      assign take[l]   = rem_sh[l] >= div_ext;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= valid_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[g]  <= div_q[g-1];
        side_q[g] <= side_q[g-1];
        for (int l = 0; l < 2; l++) begin
          rem_q[g][l] <= take[l] ? REM_W'(rem_sh[l] - div_ext) : REM_W'(rem_sh[l]);
          low_q[g][l] <= {low_q[g-1][l][QUOT_W-2:0], take[l]};
        end
      end
    end
  end

  assign valid_o  = valid_q[NS-1];
  assign quot_x_o = low_q[NS-1][0];
  assign quot_y_o = low_q[NS-1][1];
  assign side_o   = side_q[NS-1];

  // The partial remainder always stays below the divisor.
  `APV_ASSERT(a_rem_x_below_div, clk_i, rst_ni, valid_q[NS-1] |-> (rem_q[NS-1][0] < REM_W'(div_q[NS-1])), "x remainder not below divisor")
  `APV_ASSERT(a_rem_y_below_div, clk_i, rst_ni, valid_q[NS-1] |-> (rem_q[NS-1][1] < REM_W'(div_q[NS-1])), "y remainder not below divisor")

endmodule

// ===== verif/attractive_potential_velocity_tb.sv =====
// Testbench for the attractive potential velocity block: directed and random
// position requests under changing registers and handshake pressure.
// Depends on apv_pkg, the channel interfaces and the block itself.
module attractive_potential_velocity_tb;

  localparam int unsigned CW        = 16;
  localparam int unsigned LATENCY   = 50;
  localparam int unsigned CYCLE_CAP = 400000;

  typedef struct {
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic                 conical;
    logic                 sat;
  } velocity_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [apv_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [apv_pkg::CFG_W-1:0]     cfg_wdata_i;

  apv_in_if  #(.COORD_BITS(CW)) in_if ();
  apv_out_if #(.COORD_BITS(CW)) out_if ();

  attractive_potential_velocity #(.COORD_BITS(CW)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  // Shadow copy of the registers and the results still owed.
  longint unsigned shadow_sd;
  longint unsigned shadow_gain;
  velocity_t       pending_vel[$];
  int              mismatches;
  int              sender_idle_pct;
  int              receiver_stall_pct;
  int unsigned     cycle_count;

  // Clock.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Integer square root, one result bit per pass.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Puts the sign back and clips to the output width.
  function automatic logic [CW-1:0] clip_axis(longint unsigned mag, logic neg,
                                               inout logic clip);
    longint unsigned lim;
    lim = neg ? (64'd1 << (CW - 1)) : ((64'd1 << (CW - 1)) - 1);
    if (mag > lim) begin
      mag  = lim;
      clip = 1'b1;
    end
    return neg ? CW'(-mag) : CW'(mag);
  endfunction

  // Velocity command expected for one position request.
  function automatic velocity_t predict_velocity(logic signed [CW-1:0] sx, sy, gx, gy);
    longint          dx, dy;
    longint unsigned ax, ay, dist2, r, k, mx, my;
    logic            nx, ny, clip;
    velocity_t       v;
    dx    = longint'(gx) - longint'(sx);
    dy    = longint'(gy) - longint'(sy);
    nx    = dx < 0;
    ny    = dy < 0;
    ax    = nx ? -dx : dx;
    ay    = ny ? -dy : dy;
    dist2 = ax * ax + ay * ay;
    v.conical = dist2 > shadow_sd * shadow_sd;
    if (!v.conical) begin
      mx = (ax * shadow_gain + (64'd1 << (apv_pkg::GAIN_FRAC - 1))) >> apv_pkg::GAIN_FRAC;
      my = (ay * shadow_gain + (64'd1 << (apv_pkg::GAIN_FRAC - 1))) >> apv_pkg::GAIN_FRAC;
    end else begin
      r = root_floor(dist2 << apv_pkg::SQRT_EXTRA);
      if (r == 64'd0) r = 64'd1;
      k  = shadow_sd * shadow_gain;
      mx = (k * ax + (r >> 1)) / r;
      my = (k * ay + (r >> 1)) / r;
    end
    clip    = 1'b0;
    v.vel_x = clip_axis(mx, nx, clip);
    v.vel_y = clip_axis(my, ny, clip);
    v.sat   = clip;
    return v;
  endfunction

  // Reset and initial values of every input.
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.start_x = '0;
    in_if.start_y = '0;
    in_if.goal_x = '0;
    in_if.goal_y = '0;
    out_if.ready = 1'b1;
    shadow_sd    = 64'(apv_pkg::SD_RESET);
    shadow_gain  = 64'(apv_pkg::GAIN_RESET);
    mismatches   = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Receiver stalls at random according to the phase.
  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    velocity_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_vel.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result vel_x=%0d vel_y=%0d",
                                       out_if.vel_x, out_if.vel_y);
      end else begin
        want = pending_vel.pop_front();
        if (out_if.vel_x !== want.vel_x || out_if.vel_y !== want.vel_y ||
            out_if.conical_case !== want.conical || out_if.saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected vx=%0d vy=%0d con=%0b sat=%0b, got vx=%0d vy=%0d con=%0b sat=%0b",
                     want.vel_x, want.vel_y, want.conical, want.sat, out_if.vel_x,
                     out_if.vel_y, out_if.conical_case, out_if.saturated);
        end
      end
    end
  end

  // Cycle limit for a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end
  initial cycle_count = 0;

  // Sends one position request; called and returning at a falling edge.
  task automatic send_position(input logic signed [CW-1:0] sx, sy, gx, gy);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.start_x <= sx;
    in_if.start_y <= sy;
    in_if.goal_x  <= gx;
    in_if.goal_y  <= gy;
    do @(posedge clk_i); while (!in_if.ready);
    pending_vel.insert(pending_vel.size(), predict_velocity(sx, sy, gx, gy));
    @(negedge clk_i);
  endtask

  // Sends an offset from a random start point.
  task automatic send_offset(input int ox, input int oy);
    logic signed [CW-1:0] sx, sy;
    sx = CW'($urandom);
    sy = CW'($urandom);
    send_position(sx, sy, CW'(int'(sx) + ox), CW'(int'(sy) + oy));
  endtask

  // Waits for every owed result and for the pipeline to empty.
  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_vel.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  // Writes one register once the block is idle.
  task automatic write_reg(input logic [apv_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apv_pkg::CFG_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == apv_pkg::REG_SWITCH_DIST)
      shadow_sd = value & ((64'd1 << apv_pkg::SD_W) - 1);
    else if (idx == apv_pkg::REG_ATTRACT_GAIN)
      shadow_gain = value & ((64'd1 << apv_pkg::GAIN_W) - 1);
  endtask

  // Extremes of the coordinates and the named corner cases.
  task automatic test_directed;
    send_position(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);   // zero offset
    send_position(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_position(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_position(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_position(16'sh0000, 16'sh0000, 16'sd512, 16'sd0);       // exactly at the switch
    send_position(16'sh0000, 16'sh0000, 16'sd513, 16'sd0);
    send_position(16'sh0000, 16'sh0000, -16'sd362, 16'sd362);
    send_position(16'shffff, 16'shffff, 16'sh0000, 16'sh0000);
    write_reg(apv_pkg::REG_SWITCH_DIST, 15'd500);
    send_position(16'sd0, 16'sd0, 16'sd300, -16'sd400);          // 3-4-5 on the switch
    send_position(16'sd0, 16'sd0, 16'sd301, -16'sd400);
    write_reg(apv_pkg::REG_SWITCH_DIST, 15'd0);                  // any nonzero offset is conical
    send_position(16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_position(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    write_reg(apv_pkg::REG_SWITCH_DIST, 15'h7fff);
    write_reg(apv_pkg::REG_ATTRACT_GAIN, 15'h7fff);              // upper bits dropped
    send_position(16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0000);   // saturation
    send_position(16'sh7fff, 16'sh0100, 16'sh8000, 16'sh0000);
    send_position(16'sd0, 16'sd0, 16'sd200, 16'sd1);
    write_reg(apv_pkg::REG_ATTRACT_GAIN, 15'd0);                 // zero gain
    send_position(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_position(16'sd0, 16'sd0, 16'sd5, -16'sd7);
    write_reg(2'd2, 15'h1234);                                   // unused indexes
    write_reg(2'd3, 15'h7fff);
    send_position(16'sd0, 16'sd0, 16'sd5, -16'sd7);
  endtask

  // Random requests: a quarter fully random, a quarter small offsets, half offsets around the switching distance.
  task automatic test_random(input int count);
    int span;
    repeat (count) begin
      span = int'(shadow_sd) * 2 + 4;
      case ($urandom_range(3))
        0: send_position(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
        1: send_offset(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8);
        default: send_offset(int'($urandom_range(span)) - span / 2,
                             int'($urandom_range(span)) - span / 2);
      endcase
    end
  endtask

  // Each handshake phase under one register setting.
  task automatic test_phases(input logic [apv_pkg::CFG_W-1:0] sd,
                             input logic [apv_pkg::CFG_W-1:0] gain);
    write_reg(apv_pkg::REG_SWITCH_DIST, sd);
    write_reg(apv_pkg::REG_ATTRACT_GAIN, gain);
    sender_idle_pct = 0;  receiver_stall_pct = 0;  test_random(30);
    sender_idle_pct = 49; receiver_stall_pct = 0;  test_random(30);
    sender_idle_pct = 0;  receiver_stall_pct = 49; test_random(30);
    sender_idle_pct = 25; receiver_stall_pct = 25; test_random(30);
    sender_idle_pct = 0;  receiver_stall_pct = 0;
  endtask

  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    test_directed();
    test_phases(15'd512, 15'd256);
    test_phases(15'd1, 15'd4095);
    test_phases(15'h7fff, 15'd1);
    test_phases(apv_pkg::CFG_W'($urandom), apv_pkg::CFG_W'($urandom));
    test_phases(apv_pkg::CFG_W'($urandom_range(2048)), apv_pkg::CFG_W'($urandom));
    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/apv_pkg.sv
src/apv_if.sv
src/apv_front.sv
src/apv_sqrt.sv
src/apv_div.sv
src/attractive_potential_velocity.sv
verif/attractive_potential_velocity_tb.sv
